### src/assert_macros.svh
// Assertion helpers used by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BZC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define BZC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### src/bzc_pkg.sv
// ---------------------------------------------------------------------------
// bzc_pkg: shared definitions for the back-EMF zero-crossing interpolator
// Item kinds, register indexes, reset values, defaults and divider handshake.
// ---------------------------------------------------------------------------
package bzc_pkg;

  localparam int MAX_SPAN_DEF    = 32;
  localparam int TICK_RATIO_DEF  = 80;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int KIND_W   = 2;
  localparam int TICK_W   = 16;
  localparam int DB_W     = 12;
  localparam int BACK_W   = 14;
  localparam int TOTAL_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_ARM    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DISARM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AVG      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD   = 2'd3;

  localparam logic [DB_W-1:0]   DEAD_BAND_RST  = 12'd8;
  localparam logic [TICK_W-1:0] MIN_DUTY_RST   = 16'd400;
  localparam logic [TICK_W-1:0] MIN_AVG_RST    = 16'd1000;
  localparam logic [TICK_W-1:0] PWM_PERIOD_RST = 16'd4000;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### src/bemf_zero_cross_interpolator.sv
// ---------------------------------------------------------------------------
// bemf_zero_cross_interpolator: sensorless back-EMF zero-crossing detector
// Arms a search per commutation step, tracks the last sample clearly before
// the crossing and interpolates how long ago the crossing happened.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | kind, samples, timing, duty
//  out_    | output    | out_valid / out_ready | crossing, back-date, totals
//  cfg_    | input     | cfg_valid / cfg_ready | register index and data
//
//  Arm, disarm, ignored samples and samples that only update the reference
//  pass through S_DONE into the output register. A committed crossing runs
//  the serial divider for the period (S_DIVP), the shift-and-add multiplier
//  for magnitude times span and then times period (S_MUL1, S_MUL2) and the
//  divider for the back-date (S_DIVB). One item is in work at a time;
//  a finished result waits in the output register while the next item is transferred.
//  Reset restores the register defaults and clears all search state.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bemf_zero_cross_interpolator
  import bzc_pkg::*;
#(
  parameter int MAX_SPAN    = MAX_SPAN_DEF,
  parameter int TICK_RATIO  = TICK_RATIO_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [SAMPLE_BITS-1:0] in_phase_sample,
  input  logic [SAMPLE_BITS-1:0] in_common_sample,
  input  logic                   in_rising,
  input  logic [TICK_W-1:0]      in_elapsed_ticks,
  input  logic [TICK_W-1:0]      in_commutation_interval,
  input  logic [TICK_W-1:0]      in_duty_ticks,
  input  logic [TICK_W-1:0]      in_average_interval,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_crossing_found,
  output logic [BACK_W-1:0]      out_back_date,
  output logic                   out_search_armed,
  output logic                   out_arm_granted,
  output logic [TOTAL_W-1:0]     out_search_total,
  output logic [TOTAL_W-1:0]     out_accept_total,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int S      = SAMPLE_BITS;
  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int PER_W  = TICK_W;
  localparam int PW     = S + SPAN_W + PER_W;
  localparam int RW     = $clog2(TICK_RATIO + 1);
  localparam int DVW    = (S + 1 > RW) ? S + 1 : RW;
  localparam int CW     = ((S > DB_W) ? S : DB_W) + 2;
  localparam int CNT_W  = $clog2(PER_W + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIVP = 6'b000010,
    S_MUL1 = 6'b000100,
    S_MUL2 = 6'b001000,
    S_DIVB = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [DB_W-1:0]    db_r, db_nxt;
  logic [TICK_W-1:0]  min_duty_r, min_duty_nxt;
  logic [TICK_W-1:0]  min_avg_r, min_avg_nxt;
  logic [TICK_W-1:0]  pwm_r, pwm_nxt;

  logic [S-1:0]       ref_r, ref_nxt;
  logic [SPAN_W-1:0]  span_r, span_nxt;
  logic               armed_r, armed_nxt;
  logic [TOTAL_W-1:0] search_cnt_r, search_cnt_nxt;
  logic [TOTAL_W-1:0] accept_cnt_r, accept_cnt_nxt;

  logic [S-1:0]       mag_r, mag_nxt;
  logic [S:0]         dvs_r, dvs_nxt;
  logic [SPAN_W-1:0]  span_eff_r, span_eff_nxt;
  logic [BACK_W-1:0]  cap_r, cap_nxt;
  logic [PER_W-1:0]   period_r, period_nxt;
  logic [PW-1:0]      acc_r, acc_nxt;
  logic [PW-1:0]      mcand_r, mcand_nxt;
  logic [PER_W-1:0]   mplier_r, mplier_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic               res_found_r, res_found_nxt;
  logic [BACK_W-1:0]  res_back_r, res_back_nxt;
  logic               res_granted_r, res_granted_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [BACK_W-1:0]  out_back_r, out_back_nxt;
  logic               out_armed_r, out_armed_nxt;
  logic               out_granted_r, out_granted_nxt;
  logic [TOTAL_W-1:0] out_search_r, out_search_nxt;
  logic [TOTAL_W-1:0] out_accept_r, out_accept_nxt;

  logic               in_xfer;
  logic               sample_live;
  logic signed [S:0]  diff_s, d_s, neg_d;
  logic signed [CW-1:0] d_w, db_w;
  logic               is_before, is_past;
  logic [SPAN_W-1:0]  span_inc;
  logic [PW-1:0]      acc_step;
  logic [PW-1:0]      quo;

  div_ctl_t           div_ctl;
  div_sts_t           div_sts;
  logic [PW-1:0]      div_dividend;
  logic [DVW-1:0]     div_divisor;

  bzc_serial_div #(
    .NW (PW),
    .DW (DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (quo)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;

  // signed difference, normalized so that a pending crossing reads negative
  always_comb begin
    diff_s    = $signed({1'b0, in_phase_sample}) - $signed({1'b0, in_common_sample});
    d_s       = in_rising ? diff_s : -diff_s;
    neg_d     = -d_s;
    d_w       = CW'(d_s);
    db_w      = $signed(CW'(db_r));
    is_before = d_w <= -db_w;
    is_past   = d_w >= db_w;
    span_inc  = ((ref_r != '0) && (span_r < SPAN_W'(MAX_SPAN))) ?
                span_r + SPAN_W'(1) : span_r;
    sample_live = armed_r
               && (in_elapsed_ticks > {1'b0, in_commutation_interval[TICK_W-1:1]})
               && (in_duty_ticks >= min_duty_r);
    acc_step  = mplier_r[0] ? acc_r + mcand_r : acc_r;
  end

  always_comb begin
    state_nxt       = state_r;
    db_nxt          = db_r;
    min_duty_nxt    = min_duty_r;
    min_avg_nxt     = min_avg_r;
    pwm_nxt         = pwm_r;
    ref_nxt         = ref_r;
    span_nxt        = span_r;
    armed_nxt       = armed_r;
    search_cnt_nxt  = search_cnt_r;
    accept_cnt_nxt  = accept_cnt_r;
    mag_nxt         = mag_r;
    dvs_nxt         = dvs_r;
    span_eff_nxt    = span_eff_r;
    cap_nxt         = cap_r;
    period_nxt      = period_r;
    acc_nxt         = acc_r;
    mcand_nxt       = mcand_r;
    mplier_nxt      = mplier_r;
    cnt_nxt         = cnt_r;
    res_found_nxt   = res_found_r;
    res_back_nxt    = res_back_r;
    res_granted_nxt = res_granted_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_found_nxt   = out_found_r;
    out_back_nxt    = out_back_r;
    out_armed_nxt   = out_armed_r;
    out_granted_nxt = out_granted_r;
    out_search_nxt  = out_search_r;
    out_accept_nxt  = out_accept_r;
    div_ctl.start   = 1'b0;
    div_dividend    = PW'(pwm_r);
    div_divisor     = DVW'(TICK_RATIO);

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEAD_BAND:  db_nxt       = cfg_data[DB_W-1:0];
        CFG_MIN_DUTY:   min_duty_nxt = cfg_data;
        CFG_MIN_AVG:    min_avg_nxt  = cfg_data;
        CFG_PWM_PERIOD: pwm_nxt      = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_found_nxt   = 1'b0;
          res_back_nxt    = '0;
          res_granted_nxt = 1'b0;
          state_nxt       = S_DONE;
          case (in_kind)
            KIND_ARM: begin
              if ((in_average_interval >= min_avg_r) && (in_duty_ticks >= min_duty_r)) begin
                ref_nxt         = '0;
                span_nxt        = '0;
                armed_nxt       = 1'b1;
                search_cnt_nxt  = search_cnt_r + TOTAL_W'(1);
                res_granted_nxt = 1'b1;
              end
            end
            KIND_DISARM: armed_nxt = 1'b0;
            KIND_SAMPLE: begin
              if (sample_live) begin
                span_nxt = span_inc;
                if (is_before) begin
                  ref_nxt  = neg_d[S-1:0];
                  span_nxt = '0;
                end else if (is_past && (ref_r != '0)) begin
                  // straddle: start the back-date computation with the period
                  mag_nxt      = d_s[S-1:0];
                  dvs_nxt      = {1'b0, ref_r} + {1'b0, d_s[S-1:0]};
                  span_eff_nxt = (span_inc != '0) ? span_inc : SPAN_W'(1);
                  cap_nxt      = in_commutation_interval[TICK_W-1:2];
                  div_ctl.start = 1'b1;
                  state_nxt    = S_DIVP;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_DIVP: begin
        if (div_sts.done) begin
          period_nxt = quo[PER_W-1:0];
          acc_nxt    = '0;
          mcand_nxt  = PW'(mag_r);
          mplier_nxt = PER_W'(span_eff_r);
          cnt_nxt    = CNT_W'(SPAN_W);
          state_nxt  = S_MUL1;
        end
      end
      S_MUL1: begin
        acc_nxt    = acc_step;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          // magnitude times span becomes the multiplicand for the period
          acc_nxt    = '0;
          mcand_nxt  = acc_step;
          mplier_nxt = period_r;
          cnt_nxt    = CNT_W'(PER_W);
          state_nxt  = S_MUL2;
        end
      end
      S_MUL2: begin
        acc_nxt    = acc_step;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          div_ctl.start = 1'b1;
          div_dividend  = acc_step;
          div_divisor   = DVW'(dvs_r);
          state_nxt     = S_DIVB;
        end
      end
      S_DIVB: begin
        div_divisor = DVW'(dvs_r);
        if (div_sts.done) begin
          res_found_nxt  = 1'b1;
          res_back_nxt   = (quo > PW'(cap_r)) ? cap_r : quo[BACK_W-1:0];
          armed_nxt      = 1'b0;
          accept_cnt_nxt = accept_cnt_r + TOTAL_W'(1);
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_found_nxt   = res_found_r;
          out_back_nxt    = res_back_r;
          out_armed_nxt   = armed_r;
          out_granted_nxt = res_granted_r;
          out_search_nxt  = search_cnt_r;
          out_accept_nxt  = accept_cnt_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      db_r         <= DEAD_BAND_RST;
      min_duty_r   <= MIN_DUTY_RST;
      min_avg_r    <= MIN_AVG_RST;
      pwm_r        <= PWM_PERIOD_RST;
      ref_r        <= '0;
      span_r       <= '0;
      armed_r      <= 1'b0;
      search_cnt_r <= '0;
      accept_cnt_r <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      db_r         <= db_nxt;
      min_duty_r   <= min_duty_nxt;
      min_avg_r    <= min_avg_nxt;
      pwm_r        <= pwm_nxt;
      ref_r        <= ref_nxt;
      span_r       <= span_nxt;
      armed_r      <= armed_nxt;
      search_cnt_r <= search_cnt_nxt;
      accept_cnt_r <= accept_cnt_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    mag_r         <= mag_nxt;
    dvs_r         <= dvs_nxt;
    span_eff_r    <= span_eff_nxt;
    cap_r         <= cap_nxt;
    period_r      <= period_nxt;
    acc_r         <= acc_nxt;
    mcand_r       <= mcand_nxt;
    mplier_r      <= mplier_nxt;
    res_found_r   <= res_found_nxt;
    res_back_r    <= res_back_nxt;
    res_granted_r <= res_granted_nxt;
    out_found_r   <= out_found_nxt;
    out_back_r    <= out_back_nxt;
    out_armed_r   <= out_armed_nxt;
    out_granted_r <= out_granted_nxt;
    out_search_r  <= out_search_nxt;
    out_accept_r  <= out_accept_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_crossing_found = out_found_r;
  assign out_back_date      = out_back_r;
  assign out_search_armed   = out_armed_r;
  assign out_arm_granted    = out_granted_r;
  assign out_search_total   = out_search_r;
  assign out_accept_total   = out_accept_r;

  `BZC_ASSERT_IMP(a_idle_div_quiet, clk, rst_n, state_r == S_IDLE, !div_sts.busy)
  `BZC_ASSERT_IMP(a_found_disarms, clk, rst_n, out_valid_r && out_found_r, !out_armed_r)
  `BZC_ASSERT_IMP(a_grant_arms, clk, rst_n, out_valid_r && out_granted_r, out_armed_r)
  `BZC_ASSERT_NXT(a_commit_counts, clk, rst_n, (state_r == S_DIVB) && div_sts.done,
                  accept_cnt_r == $past(accept_cnt_r) + TOTAL_W'(1))

endmodule

### src/bzc_serial_div.sv
// ---------------------------------------------------------------------------
// bzc_serial_div: restoring divider, one quotient bit per cycle
// Latches dividend and divisor on start, develops NW quotient bits, then pulses done
// with the quotient held until the next start.
// ---------------------------------------------------------------------------
module bzc_serial_div
  import bzc_pkg::*;
#(
  parameter int NW = 34,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  div_ctl_t      ctl,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output div_sts_t      sts,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[NW-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};

    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (ctl.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract where it fits
      q_nxt   = {q_r[NW-2:0], ge};
      rem_nxt = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;

endmodule
